// File: rtl/ismc_pkg.sv
// shared types and constants for the integer stack machine core
// no dependencies; used by the interfaces, the divider and the top level
package ismc_pkg;

  localparam int WORD_W        = 32;
  localparam int KIND_W        = 4;
  localparam int DEPTH_W       = 9;
  localparam int STATUS_W      = 2;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [KIND_W-1:0] OP_CONST = 4'd0;
  localparam logic [KIND_W-1:0] OP_ADD   = 4'd1;
  localparam logic [KIND_W-1:0] OP_SUB   = 4'd2;
  localparam logic [KIND_W-1:0] OP_MUL   = 4'd3;
  localparam logic [KIND_W-1:0] OP_DIV   = 4'd4;
  localparam logic [KIND_W-1:0] OP_MOD   = 4'd5;
  localparam logic [KIND_W-1:0] OP_LT    = 4'd6;
  localparam logic [KIND_W-1:0] OP_LE    = 4'd7;
  localparam logic [KIND_W-1:0] OP_GT    = 4'd8;
  localparam logic [KIND_W-1:0] OP_GE    = 4'd9;
  localparam logic [KIND_W-1:0] OP_EQ    = 4'd10;
  localparam logic [KIND_W-1:0] OP_NE    = 4'd11;
  localparam logic [KIND_W-1:0] OP_NEG   = 4'd12;
  localparam logic [KIND_W-1:0] OP_RET   = 4'd13;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } div_rsp_t;

endpackage

// File: rtl/ismc_if.sv
// valid/ready channel interfaces for instruction requests and results
// depends on ismc_pkg for field widths
interface ismc_in_if;
  logic                              valid;
  logic                              ready;
  logic [ismc_pkg::KIND_W-1:0]       kind;
  logic signed [ismc_pkg::WORD_W-1:0] operand_value;

  modport source (output valid, output kind, output operand_value, input ready);
  modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface ismc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ismc_pkg::WORD_W-1:0]  top_value;
  logic [ismc_pkg::DEPTH_W-1:0]        depth;
  logic [ismc_pkg::STATUS_W-1:0]       status;
  logic                                finished;

  modport source (output valid, output top_value, output depth, output status,
                  output finished, input ready);
  modport sink   (input valid, input top_value, input depth, input status,
                  input finished, output ready);
endinterface

// File: rtl/ismc_div.sv
// iterative signed divider, one quotient bit per cycle, c-style truncation
// depends on ismc_pkg for the request and response structs
module ismc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ismc_pkg::div_req_t req,
  output ismc_pkg::div_rsp_t rsp
);

  localparam int W     = ismc_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     q_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     d_r;
  logic             neg_q_r;
  logic             neg_r_r;
  logic             is_mod_r;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] abs_a;
  logic [W-1:0] abs_b;
  logic [W-1:0] mag;
  logic         neg;

  assign abs_a   = req.a[W-1] ? (~req.a + 1'b1) : req.a;
  assign abs_b   = req.b[W-1] ? (~req.b + 1'b1) : req.b;
  assign rem_sh  = {rem_r, q_r[W-1]};
  assign diff    = rem_sh - {1'b0, d_r};
  assign take    = ~diff[W];
  assign rem_nxt = take ? diff[W-1:0] : rem_sh[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(W - 1));
      if (req.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        q_r      <= abs_a;
        d_r      <= abs_b;
        rem_r    <= '0;
        neg_q_r  <= req.a[W-1] ^ req.b[W-1];
        neg_r_r  <= req.a[W-1];
        is_mod_r <= req.is_mod;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[W-2:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign mag = is_mod_r ? rem_r : q_r;
  assign neg = is_mod_r ? neg_r_r : neg_q_r;

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = neg ? (~mag + 1'b1) : mag;

endmodule

// File: rtl/integer_stack_machine_core_unit.sv
// integer stack machine core: one bytecode instruction per request
// each instruction is accepted, then executed with the stack memory read;
// div and mod then wait in S_DIV for the 32-step iterative divider
// one instruction in flight; the output register lets the next request enter
// reset: synchronous active low, empties the stack; the stack memory is not cleared
// depends on ismc_pkg, ismc_if and ismc_div
module integer_stack_machine_core_unit #(
  parameter int STACK_DEPTH = ismc_pkg::STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ismc_in_if.sink    in_chan,
  ismc_out_if.source out_chan
);

  localparam int W    = ismc_pkg::WORD_W;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;

  state_t                          state_r;
  logic [SP_W-1:0]                 sp_r;
  logic [W-1:0]                    top_r;
  logic [ismc_pkg::KIND_W-1:0]     kind_r;
  logic [W-1:0]                    opv_r;
  logic [W-1:0]                    rd_data_r;
  logic                            out_valid_r;
  logic [W-1:0]                    out_top_r;
  logic [ismc_pkg::DEPTH_W-1:0]    out_depth_r;
  logic [ismc_pkg::STATUS_W-1:0]   out_status_r;
  logic                            out_fin_r;

  // second-from-top and below live in memory, top of stack in top_r
  logic [W-1:0] stack_mem [STACK_DEPTH];

  logic                          in_acc;
  logic [SP_W-1:0]               sp_m2;
  logic [SP_W-1:0]               sp_m1;
  logic [W-1:0]                  ex_top;
  logic [SP_W-1:0]               ex_sp;
  logic [ismc_pkg::STATUS_W-1:0] ex_status;
  logic                          ex_fin;
  logic [W-1:0]                  ret_val;
  logic [W-1:0]                  ex_out_top;
  logic                          mem_we;
  logic                          go_div;
  logic [W-1:0]                  mul_lo;
  logic signed [W-1:0]           sa;
  logic signed [W-1:0]           sb;

  ismc_pkg::div_req_t div_req;
  ismc_pkg::div_rsp_t div_rsp;

  assign in_acc         = in_chan.valid & in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) & (~out_valid_r | out_chan.ready);
  assign sp_m1          = sp_r - 1'b1;
  assign sp_m2          = sp_r - SP_W'(2);
  assign sa             = rd_data_r;
  assign sb             = top_r;
  assign mul_lo         = rd_data_r * top_r;

  always_comb begin
    ex_top    = top_r;
    ex_sp     = sp_r;
    ex_status = ismc_pkg::ST_OK;
    ex_fin    = 1'b0;
    ret_val   = '0;
    mem_we    = 1'b0;
    go_div    = 1'b0;
    case (kind_r) inside
      ismc_pkg::OP_CONST: begin
        if (sp_r == SP_W'(STACK_DEPTH)) begin
          ex_status = ismc_pkg::ST_OVER;
        end else begin
          mem_we = (sp_r != '0);
          ex_top = opv_r;
          ex_sp  = sp_r + 1'b1;
        end
      end
      [ismc_pkg::OP_ADD:ismc_pkg::OP_NE]: begin
        if (sp_r < SP_W'(2)) begin
          ex_status = ismc_pkg::ST_UNDER;
        end else begin
          ex_sp = sp_m1;
          case (kind_r)
            ismc_pkg::OP_ADD: ex_top = rd_data_r + top_r;
            ismc_pkg::OP_SUB: ex_top = rd_data_r - top_r;
            ismc_pkg::OP_MUL: ex_top = mul_lo;
            ismc_pkg::OP_DIV,
            ismc_pkg::OP_MOD: begin
              if (top_r == '0) begin
                ex_status = ismc_pkg::ST_DIVZ;
                ex_top    = '0;
              end else begin
                go_div = 1'b1;
              end
            end
            ismc_pkg::OP_LT: ex_top = W'(sa < sb);
            ismc_pkg::OP_LE: ex_top = W'(sa <= sb);
            ismc_pkg::OP_GT: ex_top = W'(sa > sb);
            ismc_pkg::OP_GE: ex_top = W'(sa >= sb);
            ismc_pkg::OP_EQ: ex_top = W'(sa == sb);
            default:         ex_top = W'(sa != sb);
          endcase
        end
      end
      ismc_pkg::OP_NEG: begin
        if (sp_r == '0) begin
          ex_status = ismc_pkg::ST_UNDER;
        end else begin
          ex_top = ~top_r + 1'b1;
        end
      end
      ismc_pkg::OP_RET: begin
        ex_fin = 1'b1;
        if (sp_r == '0) begin
          ex_status = ismc_pkg::ST_UNDER;
        end else begin
          ex_sp   = sp_m1;
          ex_top  = rd_data_r;
          ret_val = top_r;
        end
      end
      default: begin
      end
    endcase
    if (kind_r == ismc_pkg::OP_RET) begin
      ex_out_top = ret_val;
    end else begin
      ex_out_top = (ex_sp == '0) ? '0 : ex_top;
    end
  end

  assign div_req.start  = (state_r == S_EXEC) & go_div;
  assign div_req.is_mod = (kind_r == ismc_pkg::OP_MOD);
  assign div_req.a      = rd_data_r;
  assign div_req.b      = top_r;

  ismc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // stack memory, read of the second entry issued with each request
  always_ff @(posedge clk) begin
    if ((state_r == S_EXEC) && mem_we) begin
      stack_mem[sp_m1[AW-1:0]] <= top_r;
    end
    if (in_acc) begin
      rd_data_r <= stack_mem[sp_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_chan.ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_acc) begin
            kind_r  <= in_chan.kind;
            opv_r   <= in_chan.operand_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go_div) begin
            state_r <= S_DIV;
          end else begin
            top_r        <= ex_top;
            sp_r         <= ex_sp;
            out_valid_r  <= 1'b1;
            out_top_r    <= ex_out_top;
            out_depth_r  <= ismc_pkg::DEPTH_W'(ex_sp);
            out_status_r <= ex_status;
            out_fin_r    <= ex_fin;
            state_r      <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            top_r        <= div_rsp.result;
            sp_r         <= ex_sp;
            out_valid_r  <= 1'b1;
            out_top_r    <= div_rsp.result;
            out_depth_r  <= ismc_pkg::DEPTH_W'(ex_sp);
            out_status_r <= ismc_pkg::ST_OK;
            out_fin_r    <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.top_value = out_top_r;
  assign out_chan.depth     = out_depth_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.finished  = out_fin_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC && !out_valid_r)
    else $error("request accepted without a free output register");

  a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |->
      (out_status_r == ismc_pkg::ST_OK || out_status_r == ismc_pkg::ST_UNDER))
    else $error("return reported an impossible status");

endmodule
